// File: rtl/core/qhim_pkg.sv
package qhim_pkg;

   localparam int HALF_W = 16;
   localparam int WORD_W = 2 * HALF_W;

   // product in flight between multiply and reduce
   // special: an operand was zero, result already in prod[HALF_W-1:0]
   typedef struct packed {
      logic              special;
      logic [WORD_W-1:0] prod;
   } prod_type;

endpackage

// File: rtl/core/qhim_mul.sv
module qhim_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [qhim_pkg::HALF_W-1:0] in_a,
   input  logic [qhim_pkg::HALF_W-1:0] in_b,
   input  logic [qhim_pkg::HALF_W-1:0] in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output qhim_pkg::prod_type        out_prod,
   output logic [qhim_pkg::HALF_W-1:0] out_side
);

   logic                        valid_ff;
   logic                        valid_in;
   logic                        advance;
   qhim_pkg::prod_type          prod_ff;
   qhim_pkg::prod_type          prod_in;
   logic [qhim_pkg::HALF_W-1:0] side_ff;
   logic [qhim_pkg::HALF_W-1:0] one;

   assign one      = qhim_pkg::HALF_W'(1);
   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // zero operand stands for -1 mod 65537, so the product is 1 - other
   always_comb begin
      prod_in.special = 1'b0;
      prod_in.prod    = {{qhim_pkg::HALF_W{1'b0}}, in_a} * {{qhim_pkg::HALF_W{1'b0}}, in_b};
      if (in_a == '0) begin
         prod_in.special = 1'b1;
         prod_in.prod    = {{qhim_pkg::HALF_W{1'b0}}, one - in_b};
      end else if (in_b == '0) begin
         prod_in.special = 1'b1;
         prod_in.prod    = {{qhim_pkg::HALF_W{1'b0}}, one - in_a};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         prod_ff <= prod_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side_ff;

   a_special_narrow: assert property (@(posedge clock) disable iff (reset)
      valid_ff && prod_ff.special |-> prod_ff.prod[qhim_pkg::WORD_W-1:qhim_pkg::HALF_W] == '0)
      else $error("special product carries high bits");

endmodule

// File: rtl/core/qhim_red.sv
module qhim_red (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  qhim_pkg::prod_type        in_prod,
   input  logic [qhim_pkg::HALF_W-1:0] in_side,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [qhim_pkg::HALF_W-1:0] out_res,
   output logic [qhim_pkg::HALF_W-1:0] out_side
);

   logic                        valid_ff;
   logic                        valid_in;
   logic                        advance;
   logic [qhim_pkg::HALF_W-1:0] res_ff;
   logic [qhim_pkg::HALF_W-1:0] res_in;
   logic [qhim_pkg::HALF_W-1:0] side_ff;
   logic [qhim_pkg::HALF_W-1:0] p_lo;
   logic [qhim_pkg::HALF_W-1:0] p_hi;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   assign p_lo = in_prod.prod[qhim_pkg::HALF_W-1:0];
   assign p_hi = in_prod.prod[qhim_pkg::WORD_W-1:qhim_pkg::HALF_W];

   // 2^16 == -1 mod 65537: lo - hi, plus the modulus on borrow
   always_comb begin
      if (in_prod.special) begin
         res_in = p_lo;
      end else begin
         res_in = p_lo - p_hi + {{(qhim_pkg::HALF_W-1){1'b0}}, (p_lo < p_hi)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         res_ff  <= res_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/core/quasi_hadamard_idea_mixer.sv
// Mixes a 32-bit word with two chained IDEA products (multiplication mod 65537, code 0 = 65536):
// high' = high * low, then low' = high' * low; rsp_word_out = {high', low'}. One word per cycle
// sustained while the output is not stalled: each product is a 16x16 multiply stage followed by a
// mod-65537 reduce stage, and the second reduce stage is the output register. Stages advance
// independently, so empty stages fill while the output is stalled. No state beyond the pipe.
module quasi_hadamard_idea_mixer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [qhim_pkg::WORD_W-1:0] req_word_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [qhim_pkg::WORD_W-1:0] rsp_word_out
);

   logic                        s1_valid, s2_valid, s3_valid;
   logic                        s1_ready, s2_ready, s3_ready, s0_ready;
   qhim_pkg::prod_type          s1_prod, s3_prod;
   logic [qhim_pkg::HALF_W-1:0] s1_side, s2_res, s2_side, s3_side, s4_res, s4_side;

   qhim_mul u_mul_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (s0_ready),
      .in_a      (req_word_in[qhim_pkg::WORD_W-1:qhim_pkg::HALF_W]),
      .in_b      (req_word_in[qhim_pkg::HALF_W-1:0]),
      .in_side   (req_word_in[qhim_pkg::HALF_W-1:0]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_prod  (s1_prod),
      .out_side  (s1_side)
   );

   qhim_red u_red_hi (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_prod   (s1_prod),
      .in_side   (s1_side),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_res   (s2_res),
      .out_side  (s2_side)
   );

   qhim_mul u_mul_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_a      (s2_res),
      .in_b      (s2_side),
      .in_side   (s2_res),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_prod  (s3_prod),
      .out_side  (s3_side)
   );

   qhim_red u_red_lo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_prod   (s3_prod),
      .in_side   (s3_side),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_res   (s4_res),
      .out_side  (s4_side)
   );

   assign req_stall    = !s0_ready;
   assign rsp_word_out = {s4_side, s4_res};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid)
      else $error("accepted transfer lost at first stage");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid && s2_valid && s3_valid && rsp_valid)
      else $error("input stalled with a bubble in the pipe");

endmodule

// File: bench/tb_quasi_hadamard_idea_mixer.sv
`timescale 1ns / 1ps

module tb_quasi_hadamard_idea_mixer;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1080;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_LEN     = 150;
   localparam int QUIET_TAIL   = 150;
   localparam int SETTLE       = 16;

   typedef struct packed {
      logic                        drain;
      logic [qhim_pkg::WORD_W-1:0] word;
   } feed_item_type;

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_stall;
   logic [qhim_pkg::WORD_W-1:0] req_word_in = '0;
   logic                        rsp_valid;
   logic                        rsp_stall   = 1'b0;
   logic [qhim_pkg::WORD_W-1:0] rsp_word_out;

   feed_item_type               feed_q[$];
   logic [qhim_pkg::WORD_W-1:0] mixed_q[$];

   logic req_taken      = 1'b0;
   bit   draining       = 1'b0;
   bit   hold_done      = 1'b0;
   int   send_gap       = 0;
   int   recv_gap       = 0;
   int   hold_left      = 0;
   int   n_words        = 0;
   int   n_directed     = 0;
   int   words_taken    = 0;
   int   results_seen   = 0;
   int   fault_count    = 0;
   int   cycle_count    = 0;
   int   backpressure   = 0;
   int   drains_done    = 0;

   quasi_hadamard_idea_mixer uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word_in  (req_word_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word_out (rsp_word_out)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // multiplication mod 65537, code 0 stands for 65536
   function automatic logic [qhim_pkg::HALF_W-1:0] idea_mul(
      logic [qhim_pkg::HALF_W-1:0] a,
      logic [qhim_pkg::HALF_W-1:0] b
   );
      logic [32:0] ea;
      logic [32:0] eb;
      logic [32:0] rem;
      ea  = (a == '0) ? 33'h10000 : {17'b0, a};
      eb  = (b == '0) ? 33'h10000 : {17'b0, b};
      rem = (ea * eb) % 33'd65537;
      return (rem == 33'h10000) ? '0 : rem[qhim_pkg::HALF_W-1:0];
   endfunction

   function automatic logic [qhim_pkg::WORD_W-1:0] mix_word(logic [qhim_pkg::WORD_W-1:0] w);
      logic [qhim_pkg::HALF_W-1:0] hi;
      logic [qhim_pkg::HALF_W-1:0] lo;
      hi = idea_mul(w[qhim_pkg::WORD_W-1:qhim_pkg::HALF_W], w[qhim_pkg::HALF_W-1:0]);
      lo = idea_mul(hi, w[qhim_pkg::HALF_W-1:0]);
      return {hi, lo};
   endfunction

   function automatic logic [qhim_pkg::HALF_W-1:0] edge_half();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return 16'hffff;
         3: return 16'h8000;
         4: return 16'h0100;
         5: return 16'h0002;
         6: return 16'h0000 + 16'($urandom_range(0, 3));
         default: return 16'hffff - 16'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [qhim_pkg::WORD_W-1:0] random_word();
      logic [qhim_pkg::HALF_W-1:0] h;
      case ($urandom_range(0, 5))
         3: begin
            h = 16'($urandom);
            return $urandom_range(0, 1) ? {16'h0000, h} : {h, 16'h0000};
         end
         4: begin
            h = 16'($urandom);
            return $urandom_range(0, 1) ? {edge_half(), h} : {h, edge_half()};
         end
         5: return {edge_half(), edge_half()};
         default: return $urandom;
      endcase
   endfunction

   task automatic add_word(logic [qhim_pkg::WORD_W-1:0] w);
      feed_q.push_back('{drain: 1'b0, word: w});
      n_words++;
   endtask

   task automatic add_drain();
      feed_q.push_back('{drain: 1'b1, word: '0});
   endtask

   task automatic note_fault(string what, logic [qhim_pkg::WORD_W-1:0] exp_w,
                             logic [qhim_pkg::WORD_W-1:0] act_w);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s: expected %08h got %08h", $realtime, what, exp_w, act_w);
   endtask

   // stimulus feed
   always @(negedge clock) begin : drive
      logic                        v_next;
      logic [qhim_pkg::WORD_W-1:0] w_next;
      feed_item_type               item;
      v_next = req_valid;
      w_next = req_word_in;
      if (reset) begin
         v_next = 1'b0;
      end else if (!req_valid || req_taken) begin
         v_next = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (draining) begin
            if (mixed_q.size() == 0) begin
               draining = 1'b0;
               drains_done++;
            end
         end else if (feed_q.size() > 0) begin
            item = feed_q.pop_front();
            if (item.drain) begin
               draining = 1'b1;
            end else begin
               v_next = 1'b1;
               w_next = item.word;
               if (words_taken + QUIET_TAIL < n_words && ((words_taken / 128) % 3) != 2
                   && $urandom_range(0, 9) == 0)
                  send_gap = $urandom_range(1, 19);
            end
         end
      end
      req_valid   <= v_next;
      req_word_in <= w_next;
   end

   // result side back-pressure
   always @(negedge clock) begin : sink
      logic s_next;
      s_next = 1'b0;
      if (!reset) begin
         if (!hold_done && words_taken >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            s_next = 1'b1;
            hold_left--;
         end else if (recv_gap > 0) begin
            s_next = 1'b1;
            recv_gap--;
         end else if (words_taken + QUIET_TAIL < n_words && ((words_taken / 128) % 3) != 1
                      && $urandom_range(0, 11) == 0) begin
            s_next   = 1'b1;
            recv_gap = $urandom_range(1, 19) - 1;
         end
      end
      rsp_stall <= s_next;
   end

   // transfer monitor and checker
   always @(posedge clock) begin : watch
      logic [qhim_pkg::WORD_W-1:0] exp_w;
      cycle_count++;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && req_stall)
            backpressure++;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (mixed_q.size() == 0) begin
               note_fault("unexpected result", '0, rsp_word_out);
            end else begin
               exp_w = mixed_q.pop_front();
               if (rsp_word_out !== exp_w)
                  note_fault("word_out mismatch", exp_w, rsp_word_out);
            end
         end
         if (req_valid && !req_stall) begin
            mixed_q.push_back(mix_word(req_word_in));
            words_taken++;
         end
      end
   end

   initial begin : timeout
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timeout after %0d cycles, %0d words taken, %0d pending",
               cycle_count, words_taken, mixed_q.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [qhim_pkg::WORD_W-1:0] directed[];
      directed = '{
         32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0001_0000,
         32'h0000_ffff, 32'hffff_0000, 32'h0001_0001, 32'h8000_8000,
         32'h0000_8000, 32'h8000_0000, 32'hffff_0001, 32'h0001_ffff,
         32'h0000_0002, 32'h0002_0000, 32'h0100_0100, 32'h8000_0002,
         32'h0002_8000, 32'haaaa_5555, 32'h5555_aaaa, 32'h7fff_fffe,
         32'hfffe_7fff, 32'h0001_0002
      };
      foreach (directed[i])
         add_word(directed[i]);
      n_directed = n_words;
      add_drain();
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 700)
            add_drain();
         add_word(random_word());
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (words_taken < n_words || mixed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Mixed %0d words (%0d directed, zero and 65536 cases), %0d results checked",
               words_taken, n_directed, results_seen);
      $display("Input held back %0d cycles, %0d full drains, %0d faults",
               backpressure, drains_done, fault_count);
      if (fault_count == 0 && mixed_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/qhim_pkg.sv
rtl/core/qhim_mul.sv
rtl/core/qhim_red.sv
rtl/core/quasi_hadamard_idea_mixer.sv
bench/tb_quasi_hadamard_idea_mixer.sv
